FILE: src/stanley_steering_law_defines.svh
// Assertion macros for the Stanley steering law block.
`ifndef STANLEY_STEERING_LAW_DEFINES_SVH
`define STANLEY_STEERING_LAW_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define SSL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define SSL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ssl_pkg.sv
// Shared types, constants and the arctangent table of the Stanley steering law.
package ssl_pkg;

  // Datapath widths
  localparam int KE_W   = 25;  // |gain * lateral error|, Q8 mm/s
  localparam int SPD_W  = 24;  // speed << 8
  localparam int XY_W   = 28;  // CORDIC x and y
  localparam int Z_W    = 22;  // CORDIC angle accumulator, Q20
  localparam int LATE_W = 14;  // signed lateral term, Q12
  localparam int MAG_W  = 20;  // column magnitude before clamping

  localparam logic [12:0]        QUARTER_TURN  = 13'd6434;    // pi/2 in Q12
  localparam logic signed [16:0] WHEEL_LIMIT   = 17'sd24576;
  localparam logic [21:0]        DEG16_PER_RAD = 22'd3754936; // 16*180/pi, Q12

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_GAIN_K           = 3'd0,
    CFG_LATERAL_DEADBAND = 3'd1,
    CFG_DOMINANCE_RATIO  = 3'd2,
    CFG_GEAR_RATIO_LEFT  = 3'd3,
    CFG_GEAR_RATIO_RIGHT = 3'd4,
    CFG_LIMIT_LEFT       = 3'd5,
    CFG_LIMIT_RIGHT      = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  gain_k;
    logic [9:0]  lateral_deadband;
    logic [15:0] dominance_ratio;
    logic [13:0] gear_ratio_left;
    logic [13:0] gear_ratio_right;
    logic [13:0] limit_left;
    logic [13:0] limit_right;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_k:           10'd77,
    lateral_deadband: 10'd1,
    dominance_ratio:  16'd1000,
    gear_ratio_left:  14'd4096,
    gear_ratio_right: 14'd4096,
    limit_left:       14'd8000,
    limit_right:      14'd8000
  };

  // One request in flight through the angle datapath
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   forced;   // lateral term fixed, CORDIC result unused
    logic                   quarter;  // forced value is a quarter turn, else zero
    logic                   neg;      // lateral error below zero
    logic signed [15:0]     head;
  } cordic_t;

  // atan(2^-i) in Q20 radians
  function automatic logic [19:0] atan_q20(input logic [4:0] idx);
    logic [19:0] val;
    case (idx)
      5'd0:    val = 20'd823550;
      5'd1:    val = 20'd486170;
      5'd2:    val = 20'd256879;
      5'd3:    val = 20'd130396;
      5'd4:    val = 20'd65451;
      5'd5:    val = 20'd32757;
      5'd6:    val = 20'd16383;
      5'd7:    val = 20'd8192;
      5'd8:    val = 20'd4096;
      5'd9:    val = 20'd2048;
      5'd10:   val = 20'd1024;
      5'd11:   val = 20'd512;
      5'd12:   val = 20'd256;
      5'd13:   val = 20'd128;
      5'd14:   val = 20'd64;
      5'd15:   val = 20'd32;
      5'd16:   val = 20'd16;
      5'd17:   val = 20'd8;
      5'd18:   val = 20'd4;
      5'd19:   val = 20'd2;
      default: val = 20'd0;
    endcase
    return val;
  endfunction

endpackage

FILE: src/ssl_front.sv
// Front stages: error magnitude, gain product, dominance tests and CORDIC setup.
module ssl_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ssl_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  input  logic signed [15:0]    lat_err,
  input  logic signed [15:0]    head_err,
  input  logic [15:0]           spd,
  output logic                  out_valid,
  output ssl_pkg::cordic_t      out_data
);

  // Stage 1: magnitude, gain product, deadband
  logic                        s1_v_r;
  logic [ssl_pkg::KE_W-1:0]    s1_ke_r;
  logic [ssl_pkg::SPD_W-1:0]   s1_speed_r;
  logic                        s1_dead_r;
  logic                        s1_neg_r;
  logic signed [15:0]          s1_head_r;

  logic [16:0]                 err_abs17;
  logic [15:0]                 err_abs;
  logic [25:0]                 ke_full;

  always_comb begin
    err_abs17 = lat_err[15] ? (17'd0 - {lat_err[15], lat_err})
                            : {lat_err[15], lat_err};
    err_abs   = err_abs17[15:0];
    ke_full   = err_abs * cfg.gain_k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ke_r    <= ke_full[ssl_pkg::KE_W-1:0];
      s1_speed_r <= {spd, 8'd0};
      s1_dead_r  <= err_abs < {6'd0, cfg.lateral_deadband};
      s1_neg_r   <= lat_err[15];
      s1_head_r  <= head_err;
    end
  end

  // Stage 2: cross products against the dominance ratio
  logic                        s2_v_r;
  logic [39:0]                 s2_prod_s_r;
  logic [40:0]                 s2_prod_k_r;
  logic [ssl_pkg::KE_W-1:0]    s2_ke_r;
  logic [ssl_pkg::SPD_W-1:0]   s2_speed_r;
  logic                        s2_dead_r;
  logic                        s2_neg_r;
  logic signed [15:0]          s2_head_r;
  logic [39:0]                 prod_s_nxt;
  logic [40:0]                 prod_k_nxt;

  always_comb begin
    prod_s_nxt = s1_speed_r * cfg.dominance_ratio;
    prod_k_nxt = s1_ke_r * cfg.dominance_ratio;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_prod_s_r <= prod_s_nxt;
      s2_prod_k_r <= prod_k_nxt;
      s2_ke_r     <= s1_ke_r;
      s2_speed_r  <= s1_speed_r;
      s2_dead_r   <= s1_dead_r;
      s2_neg_r    <= s1_neg_r;
      s2_head_r   <= s1_head_r;
    end
  end

  // Stage 3: pick a fixed lateral term or hand off to the CORDIC
  logic                        s3_v_r;
  ssl_pkg::cordic_t            s3_d_r;
  ssl_pkg::cordic_t            s3_d_nxt;
  logic                        snap_quarter;
  logic                        snap_zero;

  always_comb begin
    snap_quarter     = s2_prod_s_r < 40'(s2_ke_r);
    snap_zero        = s2_prod_k_r < 41'(s2_speed_r);
    s3_d_nxt.x       = $signed({4'd0, s2_speed_r});
    s3_d_nxt.y       = $signed({3'd0, s2_ke_r});
    s3_d_nxt.z       = '0;
    s3_d_nxt.neg     = s2_neg_r;
    s3_d_nxt.head    = s2_head_r;
    s3_d_nxt.forced  = 1'b1;
    s3_d_nxt.quarter = 1'b0;
    if (s2_dead_r) begin
      s3_d_nxt.quarter = 1'b0;
    end else if (snap_quarter) begin
      s3_d_nxt.quarter = 1'b1;
    end else if (snap_zero) begin
      s3_d_nxt.quarter = 1'b0;
    end else if (s2_ke_r == '0) begin
      // atan2 of zero is zero
      s3_d_nxt.quarter = 1'b0;
    end else if (s2_speed_r == '0) begin
      s3_d_nxt.quarter = 1'b1;
    end else begin
      s3_d_nxt.forced  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_d_r <= s3_d_nxt;
    end
  end

  assign out_valid = s3_v_r;
  assign out_data  = s3_d_r;

endmodule

FILE: src/ssl_cordic_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
module ssl_cordic_stage #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  ssl_pkg::cordic_t      in_data,
  output logic                  out_valid,
  output ssl_pkg::cordic_t      out_data
);

  logic                          v_r;
  ssl_pkg::cordic_t              d_r;
  ssl_pkg::cordic_t              d_nxt;
  logic signed [ssl_pkg::XY_W-1:0] xs;
  logic signed [ssl_pkg::XY_W-1:0] ys;
  logic signed [ssl_pkg::Z_W-1:0]  angle;

  // Rotate toward y = 0; shifts floor toward minus infinity
  always_comb begin
    xs    = in_data.x >>> STEP;
    ys    = in_data.y >>> STEP;
    angle = $signed({2'b00, ssl_pkg::atan_q20(5'(STEP))});
    d_nxt = in_data;
    if (!in_data.y[ssl_pkg::XY_W-1]) begin
      d_nxt.x = in_data.x + ys;
      d_nxt.y = in_data.y - xs;
      d_nxt.z = in_data.z + angle;
    end else begin
      d_nxt.x = in_data.x - ys;
      d_nxt.y = in_data.y + xs;
      d_nxt.z = in_data.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule

FILE: src/ssl_wheel.sv
// Lateral term from the CORDIC angle, then wheel angle with saturation.
module ssl_wheel (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  ssl_pkg::cordic_t      in_data,
  output logic                  out_valid,
  output logic signed [15:0]    wheel_q12
);

  // Stage 1: round Q20 to Q12, cap at a quarter turn, apply sign
  logic                               w1_v_r;
  logic signed [ssl_pkg::LATE_W-1:0]  w1_late_r;
  logic signed [15:0]                 w1_head_r;
  logic signed [ssl_pkg::LATE_W-1:0]  late_nxt;
  logic [ssl_pkg::Z_W-1:0]            z_pos;
  logic [ssl_pkg::Z_W-1:0]            z_rnd;
  logic [13:0]                        z_q12;
  logic [12:0]                        mag;

  always_comb begin
    z_pos = in_data.z[ssl_pkg::Z_W-1] ? '0 : in_data.z;
    z_rnd = z_pos + 22'd128;
    z_q12 = z_rnd[ssl_pkg::Z_W-1:8];
    if (in_data.forced) begin
      mag = in_data.quarter ? ssl_pkg::QUARTER_TURN : 13'd0;
    end else if (z_q12 > {1'b0, ssl_pkg::QUARTER_TURN}) begin
      mag = ssl_pkg::QUARTER_TURN;
    end else begin
      mag = z_q12[12:0];
    end
    late_nxt = in_data.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w1_v_r <= 1'b0;
    end else if (en) begin
      w1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w1_late_r <= late_nxt;
      w1_head_r <= in_data.head;
    end
  end

  // Stage 2: heading plus lateral term, saturated
  logic                 w2_v_r;
  logic signed [15:0]   w2_wheel_r;
  logic signed [16:0]   sum;
  logic signed [15:0]   wheel_nxt;

  always_comb begin
    sum = {w1_head_r[15], w1_head_r} + {{3{w1_late_r[ssl_pkg::LATE_W-1]}}, w1_late_r};
    if (sum > ssl_pkg::WHEEL_LIMIT) begin
      wheel_nxt = 16'(ssl_pkg::WHEEL_LIMIT);
    end else if (sum < -ssl_pkg::WHEEL_LIMIT) begin
      wheel_nxt = 16'(-ssl_pkg::WHEEL_LIMIT);
    end else begin
      wheel_nxt = sum[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w2_v_r <= 1'b0;
    end else if (en) begin
      w2_v_r <= w1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w2_wheel_r <= wheel_nxt;
    end
  end

  assign out_valid = w2_v_r;
  assign wheel_q12 = w2_wheel_r;

endmodule

FILE: src/ssl_column.sv
// Column angle: gear ratio, degree conversion in split products, rounding, clamp.
module ssl_column (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ssl_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  input  logic signed [15:0]    wheel_in,
  output logic                  out_valid,
  output logic signed [15:0]    out_wheel_angle,
  output logic signed [14:0]    out_column_angle,
  output logic                  out_clamped
);

  // Stage 1: |wheel| times the gear ratio picked by sign
  logic                 c1_v_r;
  logic [28:0]          c1_prod_r;
  logic                 c1_neg_r;
  logic signed [15:0]   c1_wheel_r;
  logic [15:0]          wheel_abs;
  logic [13:0]          ratio;
  logic [28:0]          prod_nxt;

  always_comb begin
    wheel_abs = wheel_in[15] ? (16'd0 - wheel_in) : wheel_in;
    ratio     = wheel_in[15] ? cfg.gear_ratio_right : cfg.gear_ratio_left;
    prod_nxt  = wheel_abs[14:0] * ratio;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
    end else if (en) begin
      c1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_prod_r  <= prod_nxt;
      c1_neg_r   <= wheel_in[15];
      c1_wheel_r <= wheel_in;
    end
  end

  // Stage 2: degree constant times the low and high halves
  logic                 c2_v_r;
  logic [36:0]          c2_lo_r;
  logic [35:0]          c2_hi_r;
  logic                 c2_neg_r;
  logic signed [15:0]   c2_wheel_r;
  logic [36:0]          lo_nxt;
  logic [35:0]          hi_nxt;

  always_comb begin
    lo_nxt = c1_prod_r[14:0] * ssl_pkg::DEG16_PER_RAD;
    hi_nxt = c1_prod_r[28:15] * ssl_pkg::DEG16_PER_RAD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_v_r <= 1'b0;
    end else if (en) begin
      c2_v_r <= c1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2_lo_r    <= lo_nxt;
      c2_hi_r    <= hi_nxt;
      c2_neg_r   <= c1_neg_r;
      c2_wheel_r <= c1_wheel_r;
    end
  end

  // Stage 3: recombine, round half up, drop 32 fraction bits
  logic                         c3_v_r;
  logic [ssl_pkg::MAG_W-1:0]    c3_mag_r;
  logic                         c3_neg_r;
  logic signed [15:0]           c3_wheel_r;
  logic [51:0]                  full;

  always_comb begin
    full = {1'b0, c2_hi_r, 15'd0} + {15'd0, c2_lo_r} + (52'd1 << 31);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_v_r <= 1'b0;
    end else if (en) begin
      c3_v_r <= c2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3_mag_r   <= full[51:32];
      c3_neg_r   <= c2_neg_r;
      c3_wheel_r <= c2_wheel_r;
    end
  end

  // Stage 4: sign opposite the wheel, clamp to the limits (output register)
  logic                 c4_v_r;
  logic signed [15:0]   c4_wheel_r;
  logic signed [14:0]   c4_col_r;
  logic                 c4_clamped_r;
  logic signed [14:0]   col_nxt;
  logic                 clamped_nxt;

  always_comb begin
    clamped_nxt = 1'b0;
    if (c3_neg_r) begin
      if (c3_mag_r > 20'(cfg.limit_right)) begin
        col_nxt     = $signed({1'b0, cfg.limit_right});
        clamped_nxt = 1'b1;
      end else begin
        col_nxt     = $signed(c3_mag_r[14:0]);
      end
    end else begin
      if (c3_mag_r > 20'(cfg.limit_left)) begin
        col_nxt     = -$signed({1'b0, cfg.limit_left});
        clamped_nxt = 1'b1;
      end else begin
        col_nxt     = -$signed(c3_mag_r[14:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c4_v_r <= 1'b0;
    end else if (en) begin
      c4_v_r <= c3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_wheel_r   <= c3_wheel_r;
      c4_col_r     <= col_nxt;
      c4_clamped_r <= clamped_nxt;
    end
  end

  assign out_valid        = c4_v_r;
  assign out_wheel_angle  = c4_wheel_r;
  assign out_column_angle = c4_col_r;
  assign out_clamped      = c4_clamped_r;

endmodule

FILE: src/stanley_steering_law.sv
// Stanley steering law: fully pipelined, one request per cycle unless a result is stalled, no state between requests.
// Throughput: one request per cycle; the whole pipe holds only while a result is stalled.
// The CORDIC takes one pipeline stage per iteration, so ATAN_STEPS sets the depth.
// Reset (synchronous, rst_n low) empties the pipe and loads the register defaults.
`include "stanley_steering_law_defines.svh"

module stanley_steering_law #(
  parameter int ATAN_STEPS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input requests
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [15:0]   in_lateral_error,
  input  logic signed [15:0]   in_heading_error,
  input  logic [15:0]          in_wheel_speed,
  // results
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [15:0]   out_wheel_angle,
  output logic signed [14:0]   out_column_angle,
  output logic                 out_clamped,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  // Configuration registers
  ssl_pkg::cfg_t cfg_r;
  ssl_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (ssl_pkg::cfg_idx_t'(cfg_index))
        ssl_pkg::CFG_GAIN_K:           cfg_nxt.gain_k           = cfg_data[9:0];
        ssl_pkg::CFG_LATERAL_DEADBAND: cfg_nxt.lateral_deadband = cfg_data[9:0];
        ssl_pkg::CFG_DOMINANCE_RATIO:  cfg_nxt.dominance_ratio  = cfg_data;
        ssl_pkg::CFG_GEAR_RATIO_LEFT:  cfg_nxt.gear_ratio_left  = cfg_data[13:0];
        ssl_pkg::CFG_GEAR_RATIO_RIGHT: cfg_nxt.gear_ratio_right = cfg_data[13:0];
        ssl_pkg::CFG_LIMIT_LEFT:       cfg_nxt.limit_left       = cfg_data[13:0];
        ssl_pkg::CFG_LIMIT_RIGHT:      cfg_nxt.limit_right      = cfg_data[13:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ssl_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Pipe advances unless a finished result is held by the receiver
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Front stages
  ssl_pkg::cordic_t cord_d [ATAN_STEPS+1];
  logic             cord_v [ATAN_STEPS+1];

  ssl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .lat_err   (in_lateral_error),
    .head_err  (in_heading_error),
    .spd       (in_wheel_speed),
    .out_valid (cord_v[0]),
    .out_data  (cord_d[0])
  );

  // CORDIC, one iteration per stage
  for (genvar s = 0; s < ATAN_STEPS; s++) begin : g_cordic
    ssl_cordic_stage #(
      .STEP (s)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (cord_v[s]),
      .in_data   (cord_d[s]),
      .out_valid (cord_v[s+1]),
      .out_data  (cord_d[s+1])
    );
  end

  // Wheel angle
  logic               wheel_v;
  logic signed [15:0] wheel;

  ssl_wheel u_wheel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (cord_v[ATAN_STEPS]),
    .in_data   (cord_d[ATAN_STEPS]),
    .out_valid (wheel_v),
    .wheel_q12 (wheel)
  );

  // Column angle and output register
  ssl_column u_column (
    .clk              (clk),
    .rst_n            (rst_n),
    .en               (adv),
    .cfg              (cfg_r),
    .in_valid         (wheel_v),
    .wheel_in         (wheel),
    .out_valid        (out_valid),
    .out_wheel_angle  (out_wheel_angle),
    .out_column_angle (out_column_angle),
    .out_clamped      (out_clamped)
  );

  // Checks
  logic signed [14:0] lim_right_s;
  logic signed [14:0] lim_left_neg_s;
  logic               col_at_lim;
  logic               col_in_lim;
  logic               wheel_pos;
  logic               col_pos;
  logic               lim_r_wr;
  logic [13:0]        cfg_lim14;

  assign lim_right_s    = $signed({1'b0, cfg_r.limit_right});
  assign lim_left_neg_s = -$signed({1'b0, cfg_r.limit_left});
  assign col_at_lim     = (out_column_angle == lim_right_s) ||
                          (out_column_angle == lim_left_neg_s);
  assign col_in_lim     = (out_column_angle <= lim_right_s) &&
                          (out_column_angle >= lim_left_neg_s);
  assign wheel_pos      = out_valid && (out_wheel_angle > 16'sd0);
  assign col_pos        = out_column_angle > 15'sd0;
  assign lim_r_wr       = cfg_valid && cfg_ready && (cfg_index == ssl_pkg::CFG_LIMIT_RIGHT);
  assign cfg_lim14      = cfg_data[13:0];

  `SSL_ASSERT_IMPL(a_clamp_at_limit, out_valid && out_clamped, col_at_lim, "clamp not at a limit")
  `SSL_ASSERT_IMPL(a_within_limits, out_valid, col_in_lim, "column angle outside limits")
  `SSL_ASSERT_IMPL(a_sign_opposite, wheel_pos, !col_pos, "column sign follows wheel")
  `SSL_ASSERT_NEXT(a_limit_write, lim_r_wr, cfg_r.limit_right == $past(cfg_lim14), "write lost")

endmodule
